FILE: design/sspq_pkg.sv
// Shared types and constants for the stable sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
package sspq_pkg;

	localparam int DEPTH     = 16;
	localparam int PRIO_BITS = 8;
	localparam int DATA_BITS = 32;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);
	localparam int OCC_BITS  = 5;
	localparam int ADDR_BITS = 3;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_POP    = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		REG_ORDER = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic [PRIO_BITS-1:0]        prio;
		logic signed [DATA_BITS-1:0] data;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   pop;
		logic   desc;
		entry_t new_ent;
	} cell_ctl_t;

endpackage
`default_nettype wire

FILE: design/sspq_if.sv
// Valid/ready channel interfaces for queue commands and results.
`timescale 1ns / 1ps
`default_nettype none
interface sspq_in_if import sspq_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [PRIO_BITS-1:0]        priority_req;
	logic signed [DATA_BITS-1:0] data_in;

	modport source (output valid, mode, priority_req, data_in, input ready);
	modport sink (input valid, mode, priority_req, data_in, output ready);
endinterface

interface sspq_out_if import sspq_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic                        out_valid;
	logic [PRIO_BITS-1:0]        out_priority;
	logic signed [DATA_BITS-1:0] out_data;
	logic [1:0]                  status;
	logic [OCC_BITS-1:0]         occupancy;

	modport source (output valid, out_valid, out_priority, out_data, status, occupancy,
		input ready);
	modport sink (input valid, out_valid, out_priority, out_data, status, occupancy,
		output ready);
endinterface
`default_nettype wire

FILE: design/sspq_cell.sv
// One queue slot: holds an entry, compares it with the new key, shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module sspq_cell import sspq_pkg::*; (
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire logic      occupied,
	input  wire logic      chain_in,
	output logic           chain_out,
	input  wire entry_t    left_ent,
	input  wire entry_t    right_ent,
	output entry_t         ent
);

	entry_t ent_q;
	logic   ahead;

	always_comb begin
		if (ctl.desc) begin
			ahead = occupied && (ent_q.prio >= ctl.new_ent.prio);
		end else begin
			ahead = occupied && (ent_q.prio <= ctl.new_ent.prio);
		end
	end

	assign chain_out = chain_in && ahead;
	assign ent       = ent_q;

	// insert: keep if ahead, take new at first slot not ahead, else shift from head side
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!chain_in) begin
				ent_q <= left_ent;
			end else if (!ahead) begin
				ent_q <= ctl.new_ent;
			end
		end else if (ctl.pop) begin
			ent_q <= right_ent;
		end
	end

endmodule
`default_nettype wire

FILE: design/stable_sorted_priority_queue_top.sv
// Top level of the stable sorted priority queue: cell row, count, result register, APB.
//
// Usage:
//   in_ch carries one command per transfer: mode 0 inserts priority_req/data_in,
//   mode 1 pops the head entry. Entries of equal priority leave in arrival order.
//   out_ch carries exactly one result per command: out_valid/out_priority/out_data
//   for a pop, status (ok, full, empty) and occupancy after the command.
//   A result appears on out_ch in the cycle after its command transfer. Throughput
//   is one command per cycle while out_ch is not stalled; every cell of the row compares
//   its key with the new key in the same cycle and shifts with its neighbor.
//   When the receiver stalls, the result register holds and in_ch.ready drops
//   until the result is taken; a new command is taken in the cycle the result
//   leaves.
//   The APB port holds order_descending at address 0 (0 ascending, 1 descending);
//   write it only while the queue is idle.
//   Reset (arst_n low) empties the queue, clears the order bit and drops out_ch.valid.
`timescale 1ns / 1ps
`default_nettype none
module stable_sorted_priority_queue_top import sspq_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	sspq_in_if.sink                   in_ch,
	sspq_out_if.source                out_ch,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	logic                        desc_q;
	logic [CNT_BITS-1:0]         count_q;
	logic                        res_valid_q;
	logic                        res_ovalid_q;
	logic [PRIO_BITS-1:0]        res_prio_q;
	logic signed [DATA_BITS-1:0] res_data_q;
	status_t                     res_status_q;
	logic [CNT_BITS-1:0]         occ_q;

	logic                        in_fire;
	logic                        full;
	logic                        empty;
	logic [CNT_BITS-1:0]         count_d;
	cell_ctl_t                   ctl;
	entry_t                      ents [DEPTH];
	logic                        chain [DEPTH+1];

	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_BITS-1] == REG_ORDER) ? {31'd0, desc_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
				&& paddr[ADDR_BITS-1] == REG_ORDER) begin
			desc_q <= pwdata[0];
		end
	end

	assign in_ch.ready = !res_valid_q || out_ch.ready;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign full        = (count_q == CNT_BITS'(DEPTH));
	assign empty       = (count_q == '0);

	always_comb begin
		ctl.ins          = in_fire && (in_ch.mode == MODE_INSERT) && !full;
		ctl.pop          = in_fire && (in_ch.mode == MODE_POP) && !empty;
		ctl.desc         = desc_q;
		ctl.new_ent.prio = in_ch.priority_req;
		ctl.new_ent.data = in_ch.data_in;
	end

	assign chain[0] = 1'b1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_ent;
		entry_t right_ent;
		if (i == 0) begin : g_head
			assign left_ent = ctl.new_ent;
		end else begin : g_mid
			assign left_ent = ents[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_ent = ents[i];
		end else begin : g_body
			assign right_ent = ents[i+1];
		end
		sspq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (count_q > CNT_BITS'(i)),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.left_ent  (left_ent),
			.right_ent (right_ent),
			.ent       (ents[i])
		);
	end

	always_comb begin
		count_d = count_q;
		if (ctl.ins) begin
			count_d = count_q + CNT_BITS'(1);
		end else if (ctl.pop) begin
			count_d = count_q - CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (in_fire) begin
				res_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_ovalid_q <= ctl.pop;
			res_prio_q   <= ctl.pop ? ents[0].prio : '0;
			res_data_q   <= ctl.pop ? ents[0].data : '0;
			if (in_ch.mode == MODE_INSERT) begin
				res_status_q <= full ? STAT_FULL : STAT_OK;
			end else begin
				res_status_q <= empty ? STAT_EMPTY : STAT_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			occ_q <= count_d;
		end
	end

	assign out_ch.valid        = res_valid_q;
	assign out_ch.out_valid    = res_ovalid_q;
	assign out_ch.out_priority = res_prio_q;
	assign out_ch.out_data     = res_data_q;
	assign out_ch.status       = res_status_q;
	assign out_ch.occupancy    = OCC_BITS'(occ_q);

endmodule
`default_nettype wire

FILE: design/sspq_checker.sv
// Port-level assertions for the stable sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sspq_checker import sspq_pkg::*; (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_ch_valid,
	input wire logic                        out_ch_ready,
	input wire logic                        out_valid,
	input wire logic [PRIO_BITS-1:0]        out_priority,
	input wire logic signed [DATA_BITS-1:0] out_data,
	input wire logic [1:0]                  status,
	input wire logic [OCC_BITS-1:0]         occupancy
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch_valid && !out_ch_ready |=> out_ch_valid && $stable(out_data)
			&& $stable(status) && $stable(occupancy))
		else $error("stalled result changed");

	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch_valid && out_valid |-> status == STAT_OK)
		else $error("returned entry with error status");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch_valid && status == STAT_EMPTY |-> !out_valid && occupancy == '0
			&& out_priority == '0 && out_data == '0)
		else $error("empty pop result not clean");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch_valid && status == STAT_FULL |-> occupancy == OCC_BITS'(DEPTH) && !out_valid)
		else $error("full reject with wrong occupancy");

endmodule

bind stable_sorted_priority_queue_top sspq_checker u_sspq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_ch_valid (out_ch.valid),
	.out_ch_ready (out_ch.ready),
	.out_valid    (out_ch.out_valid),
	.out_priority (out_ch.out_priority),
	.out_data     (out_ch.out_data),
	.status       (out_ch.status),
	.occupancy    (out_ch.occupancy)
);
`default_nettype wire
